// ----- rtl/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the 5x5 font table of the text glyph
// rectangle generator.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int COORD_BITS     = 16;
  localparam int FIELD_BITS     = 16;
  localparam int GLYPH_ROWS     = 5;
  localparam int GLYPH_COLS     = 5;
  localparam int GLYPH_BITS     = GLYPH_ROWS * GLYPH_COLS;
  localparam int COL_W          = $clog2(GLYPH_COLS);
  localparam int SCALE_W        = 8;
  localparam int ADVANCE_FACTOR = 6;
  localparam int ADV_W          = SCALE_W + 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] rect_left;
    logic [FIELD_BITS-1:0] rect_top;
    logic [FIELD_BITS-1:0] rect_right;
    logic [FIELD_BITS-1:0] rect_bottom;
    logic                  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        origin_x;
    logic [15:0]        origin_y;
    logic [SCALE_W-1:0] pixel_scale;
  } cfg_t;

  // One glyph job: bitmap is row 0 in the top bits, leftmost pixel first.
  typedef struct packed {
    logic [GLYPH_BITS-1:0] bitmap;
    coord_t                base_x;
    coord_t                base_y;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic has_glyph(input logic [7:0] code);
    return (code inside {[8'h30:8'h39]}) || (code inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic [GLYPH_BITS-1:0] glyph_bitmap(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] f;
    case (code)
      8'h41: f = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h11};
      8'h42: f = {5'h1E, 5'h11, 5'h1F, 5'h11, 5'h1E};
      8'h43: f = {5'h1F, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h44: f = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      8'h45: f = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F};
      8'h46: f = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10};
      8'h47: f = {5'h1F, 5'h10, 5'h17, 5'h11, 5'h1F};
      8'h48: f = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      8'h49: f = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};
      8'h4A: f = {5'h1F, 5'h02, 5'h02, 5'h12, 5'h1E};
      8'h4B: f = {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
      8'h4C: f = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      8'h4D: f = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
      8'h4E: f = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
      8'h4F: f = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
      8'h50: f = {5'h1F, 5'h11, 5'h1F, 5'h10, 5'h10};
      8'h51: f = {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
      8'h52: f = {5'h1F, 5'h11, 5'h1F, 5'h12, 5'h11};
      8'h53: f = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
      8'h54: f = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: f = {5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
      8'h56: f = {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
      8'h57: f = {5'h11, 5'h11, 5'h11, 5'h15, 5'h1B};
      8'h58: f = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      8'h59: f = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
      8'h5A: f = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h30: f = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      8'h31: f = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h32: f = {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
      8'h33: f = {5'h1F, 5'h01, 5'h07, 5'h01, 5'h1F};
      8'h34: f = {5'h11, 5'h11, 5'h1F, 5'h01, 5'h01};
      8'h35: f = {5'h0F, 5'h10, 5'h1F, 5'h01, 5'h1F};
      8'h36: f = {5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F};
      8'h37: f = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      8'h38: f = {5'h1F, 5'h11, 5'h0E, 5'h11, 5'h1F};
      8'h39: f = {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/tgr_front.sv -----
// ----------------------------------------------------------------------------
// tgr_front
// Takes characters, keeps the pen offsets and turns each glyph character
// into a job for the scanner.
// ----------------------------------------------------------------------------
module tgr_front import tgr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_job
);

  coord_t          pen_dx_r, pen_dx_nxt;
  coord_t          pen_dy_r, pen_dy_nxt;
  coord_t          dx0, dy0, adv;
  logic [ADV_W-1:0] adv_full;
  logic            accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    adv_full = ADV_W'(cfg.pixel_scale) * ADV_W'(ADVANCE_FACTOR);
    adv      = COORD_BITS'(adv_full);
    dx0      = in_data.start_of_text ? '0 : pen_dx_r;
    dy0      = in_data.start_of_text ? '0 : pen_dy_r;

    pen_dx_nxt = pen_dx_r;
    pen_dy_nxt = pen_dy_r;
    if (accept) begin
      if (in_data.char_code == SPACE_CODE) begin
        pen_dx_nxt = '0;
        pen_dy_nxt = dy0 + adv;
      end else begin
        pen_dx_nxt = dx0 + adv;
        pen_dy_nxt = dy0;
      end
    end

    push            = accept && has_glyph(in_data.char_code);
    push_job.bitmap = glyph_bitmap(in_data.char_code);
    push_job.base_x = COORD_BITS'(cfg.origin_x) + dx0;
    push_job.base_y = COORD_BITS'(cfg.origin_y) + dy0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_dx_r <= '0;
      pen_dy_r <= '0;
    end else begin
      pen_dx_r <= pen_dx_nxt;
      pen_dy_r <= pen_dy_nxt;
    end
  end

endmodule

// ----- rtl/tgr_queue.sv -----
// ----------------------------------------------------------------------------
// tgr_queue
// Two-entry job queue between the character front end and the scanner.
// ----------------------------------------------------------------------------
module tgr_queue import tgr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t q_status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    q_status.valid = (count_r != '0);
    q_status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
    do_push        = push && !q_status.full;
    do_pop         = pop && q_status.valid;
    pop_job        = entry_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/tgr_back.sv -----
// ----------------------------------------------------------------------------
// tgr_back
// Glyph scanner: walks one job's bitmap a cell per cycle (a lit cell waits out
// an output stall) and emits one scaled rectangle per lit cell through a registered output.
// ----------------------------------------------------------------------------
module tgr_back import tgr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_status_t q_status,
  input  job_t      pop_job,
  output logic      pop,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                  busy_r, busy_nxt;
  logic [GLYPH_BITS-1:0] bm_r, bm_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  coord_t                x_r, x_nxt;
  coord_t                y_r, y_nxt;
  coord_t                base_x_r, base_x_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  coord_t                scale_c;
  coord_t                right_c, bottom_c;
  logic                  out_free, step, emit;

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    scale_c  = COORD_BITS'(cfg.pixel_scale);
    right_c  = x_r + scale_c;
    bottom_c = y_r + scale_c;
    out_free = !out_valid_r || !out_stall;
    // unlit cells move on regardless; lit ones wait for the output slot
    step     = busy_r && (!bm_r[GLYPH_BITS-1] || out_free);
    emit     = step && bm_r[GLYPH_BITS-1];
    pop      = !busy_r && q_status.valid;

    busy_nxt      = busy_r;
    bm_nxt        = bm_r;
    col_nxt       = col_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_x_nxt    = base_x_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (pop) begin
      busy_nxt   = 1'b1;
      bm_nxt     = pop_job.bitmap;
      col_nxt    = '0;
      x_nxt      = pop_job.base_x;
      y_nxt      = pop_job.base_y;
      base_x_nxt = pop_job.base_x;
    end else if (step) begin
      bm_nxt = bm_r << 1;
      if (col_r == COL_W'(GLYPH_COLS - 1)) begin
        col_nxt = '0;
        x_nxt   = base_x_r;
        y_nxt   = y_r + scale_c;
      end else begin
        col_nxt = col_r + 1'b1;
        x_nxt   = x_r + scale_c;
      end
      // done once no lit cell is left
      busy_nxt = (bm_nxt != '0);
    end

    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.rect_left   = FIELD_BITS'(x_r);
      out_nxt.rect_top    = FIELD_BITS'(y_r);
      out_nxt.rect_right  = FIELD_BITS'(right_c);
      out_nxt.rect_bottom = FIELD_BITS'(bottom_c);
      out_nxt.last_of_run = (bm_r[GLYPH_BITS-2:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    bm_r     <= bm_nxt;
    col_r    <= col_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    base_x_r <= base_x_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/text_glyph_rect_generator.sv -----
// ----------------------------------------------------------------------------
// text_glyph_rect_generator
// Turns a character stream into filled rectangles using a scaled 5x5 font.
// ----------------------------------------------------------------------------
// Each accepted character transaction is handled by the front end: a space
// starts a new line (pen x to zero, pen y up by six times the scale), codes
// 'A'-'Z' and '0'-'9' become a glyph job in a two-entry queue, and every
// non-space code moves the pen right by six times the scale. The scanner
// takes one job at a time, loads it and then scans one glyph cell per cycle
// up to the last lit one (at most 25 cells), putting out one rectangle per
// lit cell; last_of_run marks the final rectangle of the character. Spaces
// and codes without a glyph make no job and emit nothing. Output stall holds
// the scanner on lit cells only. Configuration registers (origin x, origin y,
// pixel scale) are written through cfg_we / cfg_index / cfg_wdata; index 3
// is ignored. Change them only while the block is idle. Coordinates wrap
// modulo 2^16.
// ----------------------------------------------------------------------------
module text_glyph_rect_generator import tgr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  logic      push, pop, back_busy;
  job_t      push_job, pop_job;

  // configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    cfg_nxt.origin_x    = cfg_wdata;
        REG_ORIGIN_Y:    cfg_nxt.origin_y    = cfg_wdata;
        REG_PIXEL_SCALE: cfg_nxt.pixel_scale = cfg_wdata[SCALE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.pixel_scale <= SCALE_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: pen tracking and glyph lookup
  tgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // decoupling queue
  tgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  // back end: cell scanner and output register
  tgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .pop_job   (pop_job),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a new rectangle only comes from a scan in progress
  a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_busy))
    else $error("rectangle issued without an active scan");

  // an idle scanner picks up a waiting job on the next cycle
  a_job_pickup: assert property (@(posedge clk) disable iff (!rst_n)
    (!back_busy && q_status.valid) |=> back_busy)
    else $error("queued job not picked up by idle scanner");

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("job pushed into full queue");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_glyph_rect_generator: character transactions
// go in, a local font predictor queues the rectangles each one must produce,
// and every result transaction is compared field by field against them.
// ----------------------------------------------------------------------------
module testbench;
  import tgr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  // Generous margin past the last result, for a queued glyph scan to end;
  // spaces and blank codes retire in the front end.
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;

  // The block ignores this index; no package name exists for it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  // Idling knobs, in percent, changed per phase.
  int idle_pct  = 0;
  int stall_pct = 0;

  // Predictor copy of the registers and pen offsets.
  coord_t     org_x    = '0;
  coord_t     org_y    = '0;
  logic [7:0] px_scale = 8'd1;
  coord_t     pen_x    = '0;
  coord_t     pen_y    = '0;

  out_item_t expected_rects[$];
  out_item_t want;
  int        fault_count = 0;

  text_glyph_rect_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // 5x5 font: 25 cells, row 0 in the top bits, leftmost pixel first.
  function automatic logic [24:0] font_cells(input logic [7:0] code);
    case (code)
      "A": return {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h11};
      "B": return {5'h1E, 5'h11, 5'h1F, 5'h11, 5'h1E};
      "C": return {5'h1F, 5'h10, 5'h10, 5'h10, 5'h1F};
      "D": return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
      "E": return {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F};
      "F": return {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10};
      "G": return {5'h1F, 5'h10, 5'h17, 5'h11, 5'h1F};
      "H": return {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "I": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F};
      "J": return {5'h1F, 5'h02, 5'h02, 5'h12, 5'h1E};
      "K": return {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
      "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "M": return {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
      "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
      "O": return {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
      "P": return {5'h1F, 5'h11, 5'h1F, 5'h10, 5'h10};
      "Q": return {5'h1F, 5'h11, 5'h11, 5'h11, 5'h1F};
      "R": return {5'h1F, 5'h11, 5'h1F, 5'h12, 5'h11};
      "S": return {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
      "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
      "V": return {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
      "W": return {5'h11, 5'h11, 5'h11, 5'h15, 5'h1B};
      "X": return {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      "Y": return {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
      "Z": return {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      "0": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      "1": return {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04};
      "2": return {5'h0E, 5'h11, 5'h06, 5'h08, 5'h1F};
      "3": return {5'h1F, 5'h01, 5'h07, 5'h01, 5'h1F};
      "4": return {5'h11, 5'h11, 5'h1F, 5'h01, 5'h01};
      "5": return {5'h0F, 5'h10, 5'h1F, 5'h01, 5'h1F};
      "6": return {5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F};
      "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      "8": return {5'h1F, 5'h11, 5'h0E, 5'h11, 5'h1F};
      "9": return {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F};
      default: return '0;
    endcase
  endfunction

  // Queues the rectangles one character draws and moves the pen.
  // All coordinate math is 16 bits wide, so wrap comes for free.
  function automatic void plot_char(input in_item_t item);
    logic [24:0] cells;
    coord_t      sc;
    coord_t      step;
    coord_t      base_x;
    coord_t      base_y;
    out_item_t   rect;
    int          lit;
    int          k;
    sc   = {8'h00, px_scale};
    step = sc * 16'd6;
    if (item.start_of_text) begin
      pen_x = '0;
      pen_y = '0;
    end
    // Space: carriage return plus line feed, nothing drawn.
    if (item.char_code == SPACE_CODE) begin
      pen_x = '0;
      pen_y = pen_y + step;
      return;
    end
    cells  = font_cells(item.char_code);
    lit    = $countones(cells);
    k      = 0;
    base_x = org_x + pen_x;
    base_y = org_y + pen_y;
    for (int row = 0; row < 5; row++) begin
      for (int col = 0; col < 5; col++) begin
        if (cells[24 - 5 * row - col]) begin
          k++;
          rect.rect_left   = base_x + coord_t'(col) * sc;
          rect.rect_top    = base_y + coord_t'(row) * sc;
          rect.rect_right  = base_x + coord_t'(col + 1) * sc;
          rect.rect_bottom = base_y + coord_t'(row + 1) * sc;
          rect.last_of_run = (k == lit);
          expected_rects.push_back(rect);
        end
      end
    end
    // A code without a glyph still advances the pen.
    pen_x = pen_x + step;
  endfunction

  // Result checker: every accepted rectangle against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rects.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected rect L=%h T=%h R=%h B=%h last=%b",
                   out_data.rect_left, out_data.rect_top, out_data.rect_right,
                   out_data.rect_bottom, out_data.last_of_run);
      end else begin
        want = expected_rects.pop_front();
        if (out_data.rect_left !== want.rect_left ||
            out_data.rect_top !== want.rect_top ||
            out_data.rect_right !== want.rect_right ||
            out_data.rect_bottom !== want.rect_bottom ||
            out_data.last_of_run !== want.last_of_run) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch exp L=%h T=%h R=%h B=%h l=%b got L=%h T=%h R=%h B=%h l=%b",
                     want.rect_left, want.rect_top, want.rect_right,
                     want.rect_bottom, want.last_of_run,
                     out_data.rect_left, out_data.rect_top, out_data.rect_right,
                     out_data.rect_bottom, out_data.last_of_run);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // One character transaction. Valid is only dropped during a gap, so a
  // back-to-back transaction never sees two assignments in one step.
  task automatic send_char(input logic [7:0] code, input logic sot);
    in_item_t item;
    item.char_code     = code;
    item.start_of_text = sot;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    plot_char(item);
  endtask

  // Register write; the predictor copy follows the index decode.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X:    org_x = data;
      REG_ORIGIN_Y:    org_y = data;
      REG_PIXEL_SCALE: px_scale = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid, wait for every queued rectangle, then let the scanner and
  // front end run dry so registers can be touched safely.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly letters and digits with spaces between words, some raw bytes.
  function automatic logic [7:0] random_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return "A" + 8'($urandom_range(25));
    if (pick < 70) return "0" + 8'($urandom_range(9));
    if (pick < 85) return SPACE_CODE;
    return 8'($urandom_range(255));
  endfunction

  // Reset values: origin 0, scale 1.
  task automatic test_reset_values();
    send_char("A", 1'b1);
    send_char("8", 1'b0);
    send_char("B", 1'b0);
    settle();
  endtask

  // Codes at and around the font ranges, space, and a start flag on a space.
  task automatic test_code_boundaries();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h2F, 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char(8'h3A, 1'b0);
    send_char(8'h40, 1'b0);
    send_char("Z", 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(SPACE_CODE, 1'b1);
    send_char("M", 1'b0);
    settle();
  endtask

  // Top-of-range registers so the coordinates wrap; the upper byte of a
  // scale write is dropped and a write to the spare index does nothing.
  task automatic test_register_extremes();
    write_reg(REG_ORIGIN_X, 16'hFFFF);
    write_reg(REG_ORIGIN_Y, 16'hFFFF);
    write_reg(REG_PIXEL_SCALE, 16'hFFFF);
    write_reg(REG_UNUSED, 16'h1234);
    send_char("W", 1'b1);
    send_char("8", 1'b0);
    send_char("Q", 1'b0);
    send_char(SPACE_CODE, 1'b0);
    send_char("K", 1'b0);
    settle();
  endtask

  // Scale zero: degenerate rectangles, pen stays put.
  task automatic test_zero_scale();
    write_reg(REG_PIXEL_SCALE, 16'h0000);
    send_char("H", 1'b1);
    send_char(SPACE_CODE, 1'b0);
    send_char("I", 1'b0);
    settle();
  endtask

  // Random text under one idling mode and one register setting.
  task automatic test_random_text(input int idle, input int stall, input int count,
                                  input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [15:0] sc);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_PIXEL_SCALE, sc);
    idle_pct  = idle;
    stall_pct = stall;
    send_char(random_code(), 1'b1);
    for (int i = 1; i < count; i++)
      send_char(random_code(), ($urandom_range(15) == 0));
    settle();
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_code_boundaries();
    test_register_extremes();
    test_zero_scale();

    test_random_text(0, 0, 25, 16'h0000, 16'h0000, 16'h0001);
    test_random_text(84, 0, 25, 16'($urandom), 16'($urandom),
                     16'($urandom_range(1, 255)));
    test_random_text(0, 84, 25, 16'($urandom), 16'($urandom),
                     16'($urandom_range(1, 16)));
    test_random_text(8, 8, 25, 16'($urandom_range(65000, 65535)), 16'($urandom),
                     16'($urandom_range(200, 255)));

    if (fault_count == 0 && expected_rects.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
